// File: design/glos_pkg.sv
package glos_pkg;

	// Field widths of the item formats; they are fixed by the item layout.
	localparam int unsigned LEVEL_W = 2;
	localparam int unsigned COORD_W = 6;
	// Error term: holds -2*63 .. 2*63 with margin.
	localparam int unsigned ERR_W   = COORD_W + 3;
	// Step counter: the walk limit dx + dy + 1 stays below 2**(COORD_W + 2).
	localparam int unsigned STEP_W  = COORD_W + 2;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef struct packed {
		op_t                  op;
		logic [LEVEL_W-1:0]   viewer_level;
		logic [COORD_W-1:0]   viewer_x;
		logic [COORD_W-1:0]   viewer_y;
		logic [LEVEL_W-1:0]   target_level;
		logic [COORD_W-1:0]   target_x;
		logic [COORD_W-1:0]   target_y;
		logic                 see_through;
	} req_item_t;

	typedef struct packed {
		logic visible;
	} rsp_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SETUP,
		ST_WALK,
		ST_DONE
	} ctl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;  // latch the accepted item
		logic write;    // write the item's tile bit into the map
		logic setup;    // derive deltas, directions and initial error
		logic step;     // advance the walk by one tile
		logic finish;   // latch the answer below
		logic result;   // answer value for finish
		logic emit;     // move the answer into the output register
	} glos_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic query_ok;    // levels match and both tiles lie inside the map
		logic at_target;   // walk position equals the target
		logic tile_clear;  // tile at the walk position is transparent
		logic steps_over;  // step count has passed the walk limit
		logic out_free;    // output register can take an answer this cycle
	} glos_status_t;

endpackage

// File: design/glos_req_if.sv
interface glos_req_if import glos_pkg::*; ();
	logic      valid;
	logic      ready;
	req_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

// File: design/glos_rsp_if.sv
interface glos_rsp_if import glos_pkg::*; ();
	logic      valid;
	logic      ready;
	rsp_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

// File: design/glos_ctl.sv
module glos_ctl import glos_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         req_valid,
	input  op_t          req_op,
	input  glos_status_t st,
	output logic         req_ready,
	output glos_cmd_t    cmd
);

	ctl_state_t state_q;
	ctl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.capture = 1'b1;
					if (req_op == OP_WRITE) begin
						cmd.write = 1'b1;
					end else begin
						state_d = ST_SETUP;
					end
				end
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				if (!st.query_ok) begin
					cmd.finish = 1'b1;
					cmd.result = 1'b0;
					state_d    = ST_DONE;
				end else begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				// Same order of tests as one iteration of the line walk.
				if (st.steps_over) begin
					cmd.finish = 1'b1;
					cmd.result = 1'b0;
					state_d    = ST_DONE;
				end else if (st.at_target) begin
					cmd.finish = 1'b1;
					cmd.result = 1'b1;
					state_d    = ST_DONE;
				end else if (!st.tile_clear) begin
					cmd.finish = 1'b1;
					cmd.result = 1'b0;
					state_d    = ST_DONE;
				end else begin
					cmd.step = 1'b1;
				end
			end
			ST_DONE: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// File: design/glos_dp.sv
module glos_dp import glos_pkg::*; #(
	parameter int unsigned MAP_WIDTH  = 64,
	parameter int unsigned MAP_HEIGHT = 64,
	parameter int unsigned NUM_LEVELS = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  req_item_t      item,
	input  glos_cmd_t      cmd,
	output glos_status_t   st,
	glos_rsp_if.source     rsp
);

	localparam int unsigned LVL_W = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
	localparam int unsigned X_W   = $clog2(MAP_WIDTH);
	localparam int unsigned Y_W   = $clog2(MAP_HEIGHT);
	localparam int unsigned AW    = LVL_W + X_W + Y_W;
	localparam int unsigned DEPTH = 1 << AW;

	// Transparency map, one bit per tile, addressed {level, column, row}.
	logic mem_q [DEPTH];
	logic rd_q;

	logic [LEVEL_W-1:0] lvl_q;
	logic [COORD_W-1:0] cx_q, cy_q, tx_q, ty_q;
	logic [COORD_W-1:0] dx_q, dy_q;
	logic               sx_q, sy_q;
	logic signed [ERR_W-1:0] err_q;
	logic [STEP_W-1:0]  steps_q, lim_q;
	logic               ok_q;
	logic               res_q;
	logic               out_valid_q;
	logic               out_vis_q;

	logic [COORD_W-1:0] dx_d, dy_d;
	logic               sx_d, sy_d;
	logic signed [ERR_W-1:0] err_init, err_next, dx_s, dy_s;
	logic               move_x, move_y;
	logic [COORD_W-1:0] cx_next, cy_next, rd_x, rd_y;
	logic [AW-1:0]      wr_addr, rd_addr;
	logic               wr_in_map, q_ok;

	assign wr_in_map = (32'(item.target_level) < NUM_LEVELS) &&
	                   (32'(item.target_x) < MAP_WIDTH) &&
	                   (32'(item.target_y) < MAP_HEIGHT);

	assign q_ok = (item.viewer_level == item.target_level) && wr_in_map &&
	              (32'(item.viewer_x) < MAP_WIDTH) && (32'(item.viewer_y) < MAP_HEIGHT);

	assign wr_addr = {LVL_W'(item.target_level), X_W'(item.target_x), Y_W'(item.target_y)};

	// Deltas and directions from the captured endpoints.
	assign dx_d = (tx_q > cx_q) ? (tx_q - cx_q) : (cx_q - tx_q);
	assign dy_d = (ty_q > cy_q) ? (ty_q - cy_q) : (cy_q - ty_q);
	assign sx_d = (cx_q < tx_q);
	assign sy_d = (cy_q < ty_q);
	assign err_init = (dx_d > dy_d) ? $signed(ERR_W'(dx_d >> 1))
	                                : -$signed(ERR_W'(dy_d >> 1));

	assign dx_s   = $signed(ERR_W'(dx_q));
	assign dy_s   = $signed(ERR_W'(dy_q));
	assign move_x = (err_q > -dx_s);
	assign move_y = (err_q < dy_s);
	assign err_next = err_q - (move_x ? dy_s : '0) + (move_y ? dx_s : '0);
	assign cx_next  = move_x ? (sx_q ? cx_q + 1'b1 : cx_q - 1'b1) : cx_q;
	assign cy_next  = move_y ? (sy_q ? cy_q + 1'b1 : cy_q - 1'b1) : cy_q;

	// The read runs one tile ahead, so the data for the walk position is ready
	// at the cycle that tests it.
	assign rd_x    = cmd.step ? cx_next : cx_q;
	assign rd_y    = cmd.step ? cy_next : cy_q;
	assign rd_addr = {LVL_W'(lvl_q), X_W'(rd_x), Y_W'(rd_y)};

	always_ff @(posedge clk) begin
		if (cmd.write && wr_in_map) begin
			mem_q[wr_addr] <= item.see_through;
		end
		rd_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			lvl_q <= item.target_level;
			cx_q  <= item.viewer_x;
			cy_q  <= item.viewer_y;
			tx_q  <= item.target_x;
			ty_q  <= item.target_y;
			ok_q  <= q_ok;
		end else if (cmd.step) begin
			cx_q <= cx_next;
			cy_q <= cy_next;
		end
		if (cmd.setup) begin
			dx_q    <= dx_d;
			dy_q    <= dy_d;
			sx_q    <= sx_d;
			sy_q    <= sy_d;
			err_q   <= err_init;
			steps_q <= '0;
			lim_q   <= STEP_W'(dx_d) + STEP_W'(dy_d) + STEP_W'(1);
		end else if (cmd.step) begin
			err_q   <= err_next;
			steps_q <= steps_q + 1'b1;
		end
		if (cmd.finish) begin
			res_q <= cmd.result;
		end
		if (cmd.emit) begin
			out_vis_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign st.query_ok   = ok_q;
	assign st.at_target  = (cx_q == tx_q) && (cy_q == ty_q);
	assign st.tile_clear = rd_q;
	assign st.steps_over = (steps_q > lim_q);
	assign st.out_free   = !out_valid_q || rsp.ready;

	assign rsp.valid        = out_valid_q;
	assign rsp.item.visible = out_vis_q;

endmodule

// File: design/grid_line_of_sight.sv
// Line-of-sight engine over tile transparency maps. The block stores one
// transparency bit per tile for NUM_LEVELS maps of MAP_WIDTH by MAP_HEIGHT
// tiles in a single on-chip memory. A write item (op = 0) sets one tile's
// bit and gives no result, and a write outside the map is dropped. A query
// item (op = 1) gives one result item: visible is 0 when the levels differ
// or a tile lies outside the map, otherwise a Bresenham line is walked from
// the viewer toward the target and the answer is 0 at the first opaque tile
// before the target (the viewer's own tile is tested, the target tile never
// is). The walk reads one map tile per cycle through the memory's registered
// read port and steps at most max(|dx|, |dy|) tiles, which is 63 for a 64 by
// 64 map. One query is processed at a time; the next item is taken as soon as
// the answer sits in the output register, even if the sink has not yet taken
// it. A tile must be written before a query's walk tests it: the memory is not
// cleared at reset, and an unwritten tile makes the answer undefined.
module grid_line_of_sight import glos_pkg::*; #(
	parameter int unsigned MAP_WIDTH  = 64,
	parameter int unsigned MAP_HEIGHT = 64,
	parameter int unsigned NUM_LEVELS = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	glos_req_if.sink   req,
	glos_rsp_if.source rsp
);

	glos_cmd_t    cmd;
	glos_status_t st;
	logic         ctl_ready;

	// The controller sequences each query: capture, setup, one walk step per
	// cycle, then handing the answer to the output register.
	glos_ctl u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_op    (req.item.op),
		.st        (st),
		.req_ready (ctl_ready),
		.cmd       (cmd)
	);

	assign req.ready = ctl_ready;

	// The datapath holds the map memory, the walk registers and the output
	// register.
	glos_dp #(
		.MAP_WIDTH  (MAP_WIDTH),
		.MAP_HEIGHT (MAP_HEIGHT),
		.NUM_LEVELS (NUM_LEVELS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (req.item),
		.cmd    (cmd),
		.st     (st),
		.rsp    (rsp)
	);

	// A write item never produces a result.
	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && req.item.op == OP_WRITE) |=> !$rose(rsp.valid))
		else $error("result appeared after a write item");

	// While a query is in flight no further item is taken.
	a_query_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && req.item.op == OP_QUERY) |=> !req.ready)
		else $error("item taken while a query was in flight");

	// A new answer is only loaded from the end of a query.
	a_answer_from_query: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(!req.ready))
		else $error("result appeared without a query in flight");

endmodule

// File: tb/sv/glos_sight_checker.sv
module glos_sight_checker import glos_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	glos_req_if  req,
	glos_rsp_if  rsp,
	output int   fails,
	output int   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LEVELS = 4;
	localparam int WIDTH  = 64;
	localparam int HEIGHT = 64;
	localparam int REPORT_LIMIT = 10;

	// Mirror of the block's transparency memory, updated by every accepted write item.
	bit tile_map [LEVELS][WIDTH][HEIGHT];
	bit visible_expected [$];
	bit want_visible;
	int mismatch_count;

	// Bresenham walk from the viewer toward the target over the mirrored map.
	function automatic bit predict_visible(input logic [LEVEL_W-1:0] lv,
			input int vx, input int vy, input int tx, input int ty);
		int cx, cy, dx, dy, sx, sy, err, e2, steps;
		cx = vx;
		cy = vy;
		dx = (tx > cx) ? tx - cx : cx - tx;
		dy = (ty > cy) ? ty - cy : cy - ty;
		sx = (cx < tx) ? 1 : -1;
		sy = (cy < ty) ? 1 : -1;
		err = (dx > dy ? dx : -dy) / 2;
		for (steps = 0; steps <= dx + dy + 1; steps++) begin
			if (cx == tx && cy == ty)
				return 1'b1;
			if (cx < 0 || cy < 0 || cx >= WIDTH || cy >= HEIGHT)
				return 1'b0;
			if (!tile_map[lv][cx][cy])
				return 1'b0;
			e2 = err;
			if (e2 > -dx) begin
				err -= dy;
				cx += sx;
			end
			if (e2 < dy) begin
				err += dx;
				cy += sy;
			end
		end
		return 1'b0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			visible_expected.delete();
			mismatch_count = 0;
			fails <= 0;
			pending <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (visible_expected.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("%0t: result item with none expected, visible %0b",
							$realtime, rsp.item.visible);
				end else begin
					want_visible = visible_expected.pop_front();
					if (rsp.item.visible !== want_visible) begin
						mismatch_count++;
						if (mismatch_count <= REPORT_LIMIT)
							$display("%0t: visible mismatch, expected %0b actual %0b",
								$realtime, want_visible, rsp.item.visible);
					end
				end
			end
			if (req.valid && req.ready) begin
				// Field widths match the map size, so no item can point outside it.
				if (req.item.op == OP_WRITE) begin
					tile_map[req.item.target_level][req.item.target_x][req.item.target_y] =
						req.item.see_through;
				end else if (req.item.viewer_level != req.item.target_level) begin
					visible_expected.push_back(1'b0);
				end else begin
					visible_expected.push_back(predict_visible(req.item.target_level,
						int'(req.item.viewer_x), int'(req.item.viewer_y),
						int'(req.item.target_x), int'(req.item.target_y)));
				end
			end
			fails <= mismatch_count;
			pending <= visible_expected.size();
		end
	end

endmodule

// File: tb/sv/grid_line_of_sight_tb.sv
module grid_line_of_sight_tb import glos_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LEVELS = 4;
	localparam int WIDTH  = 64;
	localparam int HEIGHT = 64;
	localparam int MAX_COORD = 63;

	// The longest correct stretch without any handshake is the long receiver hold-off
	// plus one full-length walk; the watchdog limit is many times that.
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_CYCLES    = 400;
	// This covers any query work still in flight.
	localparam int DRAIN_CYCLES   = 100;
	// Input items per random phase, path fill writes included. With the directed part
	// this comes to about 2000 items in all.
	localparam int ITEMS_PER_PHASE = 540;
	// Items into the last phase at which the long hold-off starts and the sender pauses.
	localparam int HOLD_AFTER  = 100;
	localparam int PAUSE_AFTER = 200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	glos_req_if req_ch ();
	glos_rsp_if rsp_ch ();

	int check_fails;
	int check_pending;

	// Idle percentages for the sender and the receiver, changed per phase.
	int req_idle_pct = 0;
	int rsp_idle_pct = 0;
	// Each increment asks the receiver process for one long hold-off.
	int hold_requests = 0;
	// Input items accepted so far.
	int items_sent = 0;

	// Tiles already written. The memory is not cleared at reset, so every tile that a
	// query's walk might read is written before the query item is offered.
	bit tile_written [LEVELS][WIDTH][HEIGHT];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	grid_line_of_sight #(
		.MAP_WIDTH (WIDTH),
		.MAP_HEIGHT(HEIGHT),
		.NUM_LEVELS(LEVELS)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	glos_sight_checker u_checker (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.fails  (check_fails),
		.pending(check_pending)
	);

	// Offers one item and returns at the edge where it is accepted. Valid is left high,
	// so back-to-back items keep it high; an idle gap lowers it on a later edge.
	task automatic send_item(input req_item_t it);
		while ($urandom_range(99) < req_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.item <= it;
		do @(posedge clk); while (!req_ch.ready);
		items_sent++;
		if (it.op == OP_WRITE)
			tile_written[it.target_level][it.target_x][it.target_y] = 1'b1;
	endtask

	// The viewer fields of a write are ignored by the block, so they carry random bits.
	task automatic send_write(input int lv, input int x, input int y, input bit clear);
		req_item_t it;
		it.op = OP_WRITE;
		it.viewer_level = LEVEL_W'($urandom_range(3));
		it.viewer_x = COORD_W'($urandom_range(MAX_COORD));
		it.viewer_y = COORD_W'($urandom_range(MAX_COORD));
		it.target_level = LEVEL_W'(lv);
		it.target_x = COORD_W'(x);
		it.target_y = COORD_W'(y);
		it.see_through = clear;
		send_item(it);
	endtask

	task automatic fill_tile(input int lv, input int x, input int y, input int clear_pct);
		if (!tile_written[lv][x][y])
			send_write(lv, x, y, $urandom_range(99) < clear_pct);
	endtask

	// Writes every unwritten tile on the line from viewer to target, the target tile
	// included, whatever the opacity of the tiles. A walk never leaves this line.
	task automatic fill_path(input int lv, input int vx, input int vy, input int tx,
			input int ty, input int clear_pct);
		int cx, cy, dx, dy, sx, sy, err, e2, n;
		cx = vx;
		cy = vy;
		dx = (tx > cx) ? tx - cx : cx - tx;
		dy = (ty > cy) ? ty - cy : cy - ty;
		sx = (cx < tx) ? 1 : -1;
		sy = (cy < ty) ? 1 : -1;
		err = (dx > dy ? dx : -dy) / 2;
		for (n = 0; n <= dx + dy + 1; n++) begin
			fill_tile(lv, cx, cy, clear_pct);
			if (cx == tx && cy == ty)
				break;
			e2 = err;
			if (e2 > -dx) begin
				err -= dy;
				cx += sx;
			end
			if (e2 < dy) begin
				err += dx;
				cy += sy;
			end
		end
	endtask

	// A query on different levels reads nothing that matters, but the two end tiles are
	// written anyway in case the block touches them before it decides.
	task automatic send_query(input int vl, input int vx, input int vy, input int tl,
			input int tx, input int ty, input int clear_pct);
		req_item_t it;
		if (vl == tl) begin
			fill_path(tl, vx, vy, tx, ty, clear_pct);
		end else begin
			fill_tile(vl, vx, vy, clear_pct);
			fill_tile(tl, tx, ty, clear_pct);
		end
		it.op = OP_QUERY;
		it.viewer_level = LEVEL_W'(vl);
		it.viewer_x = COORD_W'(vx);
		it.viewer_y = COORD_W'(vy);
		it.target_level = LEVEL_W'(tl);
		it.target_x = COORD_W'(tx);
		it.target_y = COORD_W'(ty);
		it.see_through = 1'($urandom_range(1));
		send_item(it);
	endtask

	function automatic int clamp_coord(input int c);
		return (c < 0) ? 0 : (c > MAX_COORD) ? MAX_COORD : c;
	endfunction

	// Most queries are short lines, so that a fair share of them end up visible;
	// the rest span the whole map.
	task automatic random_query();
		int lv, vx, vy, tx, ty, span;
		lv = $urandom_range(LEVELS - 1);
		vx = $urandom_range(MAX_COORD);
		vy = $urandom_range(MAX_COORD);
		if ($urandom_range(99) < 70) begin
			span = $urandom_range(15);
			tx = clamp_coord(vx + int'($urandom_range(2 * span)) - span);
			ty = clamp_coord(vy + int'($urandom_range(2 * span)) - span);
		end else begin
			tx = $urandom_range(MAX_COORD);
			ty = $urandom_range(MAX_COORD);
		end
		send_query(lv, vx, vy, lv, tx, ty, 95);
	endtask

	task automatic random_item();
		int r, vl;
		r = $urandom_range(99);
		if (r < 65) begin
			random_query();
		end else if (r < 85) begin
			send_write($urandom_range(LEVELS - 1), $urandom_range(MAX_COORD),
				$urandom_range(MAX_COORD), $urandom_range(99) < 75);
		end else begin
			// Levels differ: the answer is not visible, whatever the map holds.
			vl = $urandom_range(LEVELS - 1);
			send_query(vl, $urandom_range(MAX_COORD), $urandom_range(MAX_COORD),
				(vl + int'($urandom_range(1, LEVELS - 1))) % LEVELS,
				$urandom_range(MAX_COORD), $urandom_range(MAX_COORD), 95);
		end
	endtask

	// Stops offering items until every expected result item has been taken. The first
	// edge lets the checker count a query accepted at the edge just passed.
	task automatic wait_for_answers();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (check_pending != 0)
			@(posedge clk);
	endtask

	// Receiver: random stalls at the current rate, or a long counted hold-off when the
	// stimulus asks for one.
	initial begin : receiver
		int hold_left;
		int hold_seen;
		rsp_ch.ready = 1'b0;
		hold_left = 0;
		hold_seen = 0;
		forever begin
			@(posedge clk);
			if (hold_seen != hold_requests) begin
				hold_seen = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
			end
		end
	end

	// Watchdog: ends the run when no item moves on either channel for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAIL");
		$finish;
	end

	initial begin : stimulus
		int phase;
		int phase_start;
		bit hold_asked;
		bit paused;
		req_ch.valid = 1'b0;
		req_ch.item = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, with fully transparent path fills so the outcome is known
		// by construction. The same tile is visible at both map corners.
		send_write(0, 0, 0, 1'b1);
		send_query(0, 0, 0, 0, 0, 0, 100);
		send_query(3, MAX_COORD, MAX_COORD, 3, MAX_COORD, MAX_COORD, 100);
		// Viewer and target on different levels are never visible.
		send_query(0, 0, 0, 3, MAX_COORD, MAX_COORD, 100);
		// Full diagonals in both directions, and the anti-diagonal.
		send_query(3, 0, 0, 3, MAX_COORD, MAX_COORD, 100);
		send_query(3, MAX_COORD, MAX_COORD, 3, 0, 0, 100);
		send_query(2, 0, MAX_COORD, 2, MAX_COORD, 0, 100);
		// An opaque tile halfway along a row blocks the view across it, a target just
		// beside it stays visible, and an opaque target tile is still seen.
		send_write(1, 30, 5, 1'b0);
		send_query(1, 0, 5, 1, MAX_COORD, 5, 100);
		send_query(1, MAX_COORD, 5, 1, 31, 5, 100);
		send_query(1, MAX_COORD, 5, 1, 30, 5, 100);
		// The viewer's own tile is tested.
		send_write(2, 10, 10, 1'b0);
		send_query(2, 10, 10, 2, 20, 15, 100);
		// Vertical, steep backward and shallow lines.
		send_query(2, 20, 0, 2, 20, MAX_COORD, 100);
		send_query(2, 5, 60, 2, 0, 3, 100);
		send_query(2, 12, 40, 2, 50, 41, 100);
		// Rewriting a tile on that column blocks and then clears the view again.
		send_write(2, 20, 30, 1'b0);
		send_query(2, 20, 0, 2, 20, MAX_COORD, 100);
		send_write(2, 20, 30, 1'b1);
		send_query(2, 20, 0, 2, 20, MAX_COORD, 100);
		wait_for_answers();

		// Random part in three phases: a slow receiver, then a slow sender, then no
		// idling at all, where the receiver also holds off for a long stretch.
		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					req_idle_pct = 27;
					rsp_idle_pct = 74;
				end
				1: begin
					req_idle_pct = 74;
					rsp_idle_pct = 27;
				end
				default: begin
					req_idle_pct = 0;
					rsp_idle_pct = 0;
				end
			endcase
			phase_start = items_sent;
			hold_asked = 1'b0;
			paused = 1'b0;
			while (items_sent - phase_start < ITEMS_PER_PHASE) begin
				// The sender keeps offering items during the hold-off, so the block
				// parks one answer, finishes the next query and stalls its input.
				if (phase == 2 && !hold_asked && items_sent - phase_start >= HOLD_AFTER) begin
					hold_asked = 1'b1;
					hold_requests++;
				end
				if (phase == 2 && !paused && items_sent - phase_start >= PAUSE_AFTER) begin
					paused = 1'b1;
					wait_for_answers();
				end
				random_item();
			end
			wait_for_answers();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (check_fails == 0 && check_pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
